>>> design/ltd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types, codes and constants of the load cell tap detector.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int NUM_CELLS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 24;

  // one calibration register per addressable cell
  localparam int CAL_REGS  = 4;
  localparam int CELL_W    = 2;
  localparam int REG_IDX_W = 3;

  localparam int TAP_W    = 25;
  localparam int WEIGHT_W = 26;
  localparam int HOLD_W   = 16;

  // 0.6 as 39322 / 2^16
  localparam int              FRAC_SHIFT = 16;
  localparam logic [15:0]     FRAC_NUM   = 16'd39322;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP    = 3'd0,
    REG_WEIGHT = 3'd1,
    REG_HOLD   = 3'd2,
    REG_CAL0   = 3'd3,
    REG_CAL1   = 3'd4,
    REG_CAL2   = 3'd5,
    REG_CAL3   = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_WEIGHT = 2'd2,
    EV_SUM    = 2'd3
  } event_t;

  typedef struct packed {
    logic [TAP_W-1:0]    tap;
    logic [WEIGHT_W-1:0] weight;
    logic [HOLD_W-1:0]   hold;
  } thresh_t;

  localparam logic [TAP_W-1:0]    TAP_RST    = 25'd3000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 26'd30000;
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd350;

  typedef struct packed {
    logic              sample_rejected;
    logic [CELL_W-1:0] trigger_cell;
    event_t            trigger_event;
    logic              trigger_active;
  } result_t;

endpackage

>>> design/ltd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_cfg_regs
// Configuration registers; keeps the scaled zero limit of each cell alongside.
// ----------------------------------------------------------------------------
module ltd_cfg_regs #(
  parameter int SAMPLE_BITS = ltd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ltd_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [2*SAMPLE_BITS-1:0]               cfg_data,
  output ltd_pkg::thresh_t                       thresh,
  output logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS-1:0]    offset,
  output logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS+15:0]   zero_lim
);

  localparam int ZL_W = SAMPLE_BITS + 16;

  ltd_pkg::thresh_t                              thresh_r;
  logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS-1:0] offset_r;
  logic [ltd_pkg::CAL_REGS-1:0][ZL_W-1:0]        zero_lim_r;

  logic [SAMPLE_BITS-1:0] zero_val;
  logic [SAMPLE_BITS-1:0] zero_mag;
  logic [ZL_W-1:0]        zero_lim_nxt;
  logic                   cal_wr;
  logic [1:0]             cal_sel;

  assign cfg_ready = 1'b1;

  // |zero| * 0.6 scaled by 2^16, worked out once on the write
  assign zero_val     = cfg_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign zero_mag     = zero_val[SAMPLE_BITS-1] ? (~zero_val + 1'b1) : zero_val;
  assign zero_lim_nxt = ZL_W'(zero_mag) * ZL_W'(ltd_pkg::FRAC_NUM);

  always_comb begin
    cal_wr  = 1'b0;
    cal_sel = 2'd0;
    unique case (cfg_index)
      ltd_pkg::REG_CAL0: begin cal_wr = 1'b1; cal_sel = 2'd0; end
      ltd_pkg::REG_CAL1: begin cal_wr = 1'b1; cal_sel = 2'd1; end
      ltd_pkg::REG_CAL2: begin cal_wr = 1'b1; cal_sel = 2'd2; end
      ltd_pkg::REG_CAL3: begin cal_wr = 1'b1; cal_sel = 2'd3; end
      default: begin cal_wr = 1'b0; cal_sel = 2'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.tap    <= ltd_pkg::TAP_RST;
      thresh_r.weight <= ltd_pkg::WEIGHT_RST;
      thresh_r.hold   <= ltd_pkg::HOLD_RST;
      offset_r        <= '0;
      zero_lim_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ltd_pkg::REG_TAP) begin
        thresh_r.tap <= cfg_data[ltd_pkg::TAP_W-1:0];
      end
      if (cfg_index == ltd_pkg::REG_WEIGHT) begin
        thresh_r.weight <= cfg_data[ltd_pkg::WEIGHT_W-1:0];
      end
      if (cfg_index == ltd_pkg::REG_HOLD) begin
        thresh_r.hold <= cfg_data[ltd_pkg::HOLD_W-1:0];
      end
      if (cal_wr) begin
        offset_r[cal_sel]   <= cfg_data[SAMPLE_BITS-1:0];
        zero_lim_r[cal_sel] <= zero_lim_nxt;
      end
    end
  end

  assign thresh   = thresh_r;
  assign offset   = offset_r;
  assign zero_lim = zero_lim_r;

endmodule

>>> design/ltd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_front
// Input register: offset removal and spike rejection test per sample.
// ----------------------------------------------------------------------------
module ltd_front #(
  parameter int SAMPLE_BITS = ltd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ltd_pkg::op_t                           in_op,
  input  logic [ltd_pkg::CELL_W-1:0]             in_cell,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS-1:0]  offset,
  input  logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS+15:0] zero_lim,
  input  logic                                   advance,
  output logic                                   item_valid,
  output ltd_pkg::op_t                           item_op,
  output logic [ltd_pkg::CELL_W-1:0]             item_cell,
  output logic signed [SAMPLE_BITS:0]            item_cur,
  output logic [SAMPLE_BITS:0]                   item_mag,
  output logic                                   item_rej
);

  localparam int LHS_W = SAMPLE_BITS + 1 + ltd_pkg::FRAC_SHIFT;

  logic                           valid_r;
  ltd_pkg::op_t                   op_r;
  logic [ltd_pkg::CELL_W-1:0]     cell_r;
  logic signed [SAMPLE_BITS:0]    cur_r;
  logic [SAMPLE_BITS:0]           mag_r;
  logic                           rej_r;

  logic signed [SAMPLE_BITS:0]    raw_x;
  logic signed [SAMPLE_BITS:0]    off_x;
  logic signed [SAMPLE_BITS:0]    cur_nxt;
  logic [SAMPLE_BITS:0]           mag_nxt;
  logic [LHS_W-1:0]               lhs;
  logic                           rej_nxt;
  logic                           take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  assign raw_x   = {in_sample[SAMPLE_BITS-1], in_sample};
  assign off_x   = {offset[in_cell][SAMPLE_BITS-1], offset[in_cell]};
  assign cur_nxt = raw_x - off_x;
  assign mag_nxt = cur_nxt[SAMPLE_BITS] ? unsigned'(-cur_nxt) : unsigned'(cur_nxt);
  // |cur| * 2^16 > |zero| * 39322
  assign lhs     = LHS_W'(mag_nxt) << ltd_pkg::FRAC_SHIFT;
  assign rej_nxt = lhs > LHS_W'(zero_lim[in_cell]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= in_op;
      cell_r <= in_cell;
      cur_r  <= cur_nxt;
      mag_r  <= mag_nxt;
      rej_r  <= rej_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item_op    = op_r;
  assign item_cell  = cell_r;
  assign item_cur   = cur_r;
  assign item_mag   = mag_r;
  assign item_rej   = rej_r;

endmodule

>>> design/ltd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_core
// Per-cell state, trigger tests, hold timer and result register.
// ----------------------------------------------------------------------------
module ltd_core #(
  parameter int NUM_CELLS   = ltd_pkg::NUM_CELLS_DEF,
  parameter int SAMPLE_BITS = ltd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ltd_pkg::thresh_t              thresh,
  input  logic                          item_valid,
  input  ltd_pkg::op_t                  item_op,
  input  logic [ltd_pkg::CELL_W-1:0]    item_cell,
  input  logic signed [SAMPLE_BITS:0]   item_cur,
  input  logic [SAMPLE_BITS:0]          item_mag,
  input  logic                          item_rej,
  output logic                          advance,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ltd_pkg::result_t              res
);

  localparam int RD_W   = SAMPLE_BITS + 1;
  localparam int CH_W   = SAMPLE_BITS + 2;
  localparam int TSUM_W = RD_W + $clog2(NUM_CELLS);
  localparam int CSUM_W = CH_W + $clog2(NUM_CELLS);
  localparam int CMP_W  = (CSUM_W > ltd_pkg::WEIGHT_W) ? CSUM_W : ltd_pkg::WEIGHT_W;

  logic signed [RD_W-1:0] reading_r [NUM_CELLS];
  logic [RD_W-1:0]        rmag_r    [NUM_CELLS];
  logic [CH_W-1:0]        change_r  [NUM_CELLS];
  logic                   trig_r, trig_nxt;
  logic [ltd_pkg::HOLD_W-1:0] elapsed_r, elapsed_nxt;
  logic                   out_valid_r;
  ltd_pkg::result_t       out_r, out_nxt;

  logic [NUM_CELLS-1:0]   hit;
  logic                   in_range;
  logic                   fire;
  logic                   is_sample;
  logic signed [RD_W-1:0] prev;
  logic [RD_W-1:0]        prev_mag;
  logic signed [RD_W-1:0] cur_sel;
  logic [RD_W-1:0]        mag_sel;
  logic signed [CH_W-1:0] diff;
  logic [CH_W-1:0]        chg;
  logic [TSUM_W-1:0]      tsum;
  logic [CSUM_W-1:0]      csum;
  ltd_pkg::event_t        ev;
  logic [ltd_pkg::HOLD_W-1:0] elapsed_inc;

  assign advance   = !out_valid_r || res_ready;
  assign fire      = item_valid && advance;
  assign in_range  = 32'(item_cell) < NUM_CELLS;
  assign is_sample = (item_op == ltd_pkg::OP_SAMPLE) && in_range;

  always_comb begin
    prev     = '0;
    prev_mag = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      hit[i] = 32'(item_cell) == i;
      if (hit[i]) begin
        prev     = reading_r[i];
        prev_mag = rmag_r[i];
      end
    end
  end

  // rejected sample falls back on the previous reading
  assign cur_sel = item_rej ? prev : item_cur;
  assign mag_sel = item_rej ? prev_mag : item_mag;
  assign diff    = CH_W'(cur_sel) - CH_W'(prev);
  assign chg     = diff[CH_W-1] ? unsigned'(-diff) : unsigned'(diff);

  // sums over the state as it stands after this sample
  always_comb begin
    tsum = '0;
    csum = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      tsum = tsum + TSUM_W'(hit[i] ? mag_sel : rmag_r[i]);
      csum = csum + CSUM_W'(hit[i] ? chg : change_r[i]);
    end
  end

  always_comb begin
    priority if (CMP_W'(chg) >= CMP_W'(thresh.tap)) begin
      ev = ltd_pkg::EV_SINGLE;
    end else if (CMP_W'(tsum) > CMP_W'(thresh.weight)) begin
      ev = ltd_pkg::EV_WEIGHT;
    end else if (CMP_W'(csum) >= CMP_W'(thresh.tap)) begin
      ev = ltd_pkg::EV_SUM;
    end else begin
      ev = ltd_pkg::EV_NONE;
    end
  end

  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    trig_nxt    = trig_r;
    elapsed_nxt = elapsed_r;
    out_nxt.trigger_event   = ltd_pkg::EV_NONE;
    out_nxt.trigger_cell    = '0;
    out_nxt.sample_rejected = 1'b0;
    if (item_op == ltd_pkg::OP_TICK) begin
      if (trig_r) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= thresh.hold) begin
          trig_nxt = 1'b0;
        end
      end
    end else if (in_range) begin
      out_nxt.sample_rejected = item_rej;
      if (!trig_r && ev != ltd_pkg::EV_NONE) begin
        out_nxt.trigger_event = ev;
        if (ev == ltd_pkg::EV_SINGLE) begin
          out_nxt.trigger_cell = item_cell;
        end
        elapsed_nxt = '0;
        trig_nxt    = thresh.hold != '0;
      end
    end
    out_nxt.trigger_active = trig_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        reading_r[i] <= '0;
        rmag_r[i]    <= '0;
        change_r[i]  <= '0;
      end
      trig_r      <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        trig_r    <= trig_nxt;
        elapsed_r <= elapsed_nxt;
        if (is_sample) begin
          for (int i = 0; i < NUM_CELLS; i++) begin
            if (hit[i]) begin
              reading_r[i] <= cur_sel;
              rmag_r[i]    <= mag_sel;
              change_r[i]  <= chg;
            end
          end
        end
      end
      if (advance) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

>>> design/loadcell_tap_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loadcell_tap_detector
// Tap and overload detector over interleaved load cell samples and ms ticks.
// ----------------------------------------------------------------------------
// Path: input register, then state update and result register.
// Throughput: one item per cycle while the result stream is not stalled;
//   the per-cell state update and the flat sums are combinational between
//   the two registers.
// Reset: synchronous, active low; clears all cell readings and changes, the
//   trigger and hold timer, and loads the register defaults (3000 / 30000 /
//   350, calibration zero). No clearing pass, items accepted right after.
// ----------------------------------------------------------------------------
module loadcell_tap_detector #(
  parameter int NUM_CELLS   = ltd_pkg::NUM_CELLS_DEF,
  parameter int SAMPLE_BITS = ltd_pkg::SAMPLE_BITS_DEF,
  // derived port widths
  parameter int IN_DATA_W   = ((ltd_pkg::CELL_W + SAMPLE_BITS + 7) / 8) * 8,
  parameter int CFG_DATA_W  = 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] cell_index, [SAMPLE_BITS+1:2] raw_sample, zero fill above
  input  logic [IN_DATA_W-1:0]          in_tdata,
  // [0] operation (0 sample, 1 tick)
  input  logic                          in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] trigger_active, [2:1] trigger_event, [4:3] trigger_cell,
  // [5] sample_rejected, [7:6] zero
  output logic [7:0]                    out_tdata,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ltd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  ltd_pkg::thresh_t                                 thresh;
  logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS-1:0]    offset;
  logic [ltd_pkg::CAL_REGS-1:0][SAMPLE_BITS+15:0]   zero_lim;

  logic                         advance;
  logic                         item_valid;
  ltd_pkg::op_t                 item_op;
  logic [ltd_pkg::CELL_W-1:0]   item_cell;
  logic signed [SAMPLE_BITS:0]  item_cur;
  logic [SAMPLE_BITS:0]         item_mag;
  logic                         item_rej;
  ltd_pkg::result_t             res;
  ltd_pkg::op_t                 in_op;

  assign in_op = ltd_pkg::op_t'(in_tuser);

  // config: offsets and scaled zero limits feed the front, thresholds the core
  ltd_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thresh    (thresh),
    .offset    (offset),
    .zero_lim  (zero_lim)
  );

  // front: offset removal and rejection flag, registered on the transfer
  ltd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_op),
    .in_cell    (in_tdata[ltd_pkg::CELL_W-1:0]),
    .in_sample  (signed'(in_tdata[ltd_pkg::CELL_W+SAMPLE_BITS-1:ltd_pkg::CELL_W])),
    .offset     (offset),
    .zero_lim   (zero_lim),
    .advance    (advance),
    .item_valid (item_valid),
    .item_op    (item_op),
    .item_cell  (item_cell),
    .item_cur   (item_cur),
    .item_mag   (item_mag),
    .item_rej   (item_rej)
  );

  // core: state update, tests in priority order, hold timer, result register
  ltd_core #(
    .NUM_CELLS   (NUM_CELLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .thresh     (thresh),
    .item_valid (item_valid),
    .item_op    (item_op),
    .item_cell  (item_cell),
    .item_cur   (item_cur),
    .item_mag   (item_mag),
    .item_rej   (item_rej),
    .advance    (advance),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {2'b00, res};

endmodule

>>> bench/ltd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd_checker
// Watches the sample, result and register channels of the tap detector. It
// keeps its own copy of the cell state and register settings, works out the
// result of every accepted sample or tick and compares each result transfer,
// field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module ltd_checker
  import ltd_pkg::*;
#(
  parameter int IN_W = ((CELL_W + SAMPLE_BITS_DEF + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [2*SAMPLE_BITS_DEF-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int NCELL = NUM_CELLS_DEF;
  localparam int SB    = SAMPLE_BITS_DEF;

  // register copies
  logic [TAP_W-1:0]    tap_thr;
  logic [WEIGHT_W-1:0] weight_thr;
  logic [HOLD_W-1:0]   hold_len;
  logic [2*SB-1:0]     cell_cal [CAL_REGS];

  // cell and trigger state
  logic signed [SB:0]  reading [NCELL];
  logic [SB+1:0]       swing [NCELL];
  logic                held_on;
  logic [HOLD_W-1:0]   held_for;

  result_t awaited_reports [$];
  int      errors = 0;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Applies one sample or tick to the state copy and returns its result.
  function automatic result_t detect_tap(input op_t op, input logic [CELL_W-1:0] cell_id,
                                         input logic signed [SB-1:0] raw);
    result_t r;
    longint  offs, zro, prior, cur, wsum, dsum;
    r = '0;
    if (op == OP_TICK) begin
      if (held_on) begin
        if (held_for != '1) held_for++;
        if (held_for >= hold_len) held_on = 1'b0;
      end
    end else begin
      offs  = $signed(cell_cal[cell_id][SB-1:0]);
      zro   = $signed(cell_cal[cell_id][2*SB-1:SB]);
      prior = reading[cell_id];
      cur   = raw - offs;
      // beyond 0.6 of the zero value: keep the last good reading
      if ((magnitude(cur) << FRAC_SHIFT) > magnitude(zro) * FRAC_NUM) begin
        cur = prior;
        r.sample_rejected = 1'b1;
      end
      swing[cell_id]   = (SB+2)'(magnitude(cur - prior));
      reading[cell_id] = (SB+1)'(cur);
      if (!held_on) begin
        wsum = 0;
        dsum = 0;
        for (int i = 0; i < NCELL; i++) begin
          wsum += magnitude(reading[i]);
          dsum += swing[i];
        end
        if (swing[cell_id] >= tap_thr) begin
          r.trigger_event = EV_SINGLE;
          r.trigger_cell  = cell_id;
        end else if (wsum > weight_thr) begin
          r.trigger_event = EV_WEIGHT;
        end else if (dsum >= tap_thr) begin
          r.trigger_event = EV_SUM;
        end
        if (r.trigger_event != EV_NONE) begin
          held_for = '0;
          held_on  = (hold_len != 0);
        end
      end
    end
    r.trigger_active = held_on;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen, want;
    if (!rst_n) begin
      tap_thr    = TAP_RST;
      weight_thr = WEIGHT_RST;
      hold_len   = HOLD_RST;
      for (int i = 0; i < CAL_REGS; i++) cell_cal[i] = '0;
      for (int i = 0; i < NCELL; i++) begin
        reading[i] = '0;
        swing[i]   = '0;
      end
      held_on  = 1'b0;
      held_for = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TAP:    tap_thr    = cfg_data[TAP_W-1:0];
          REG_WEIGHT: weight_thr = cfg_data[WEIGHT_W-1:0];
          REG_HOLD:   hold_len   = cfg_data[HOLD_W-1:0];
          REG_CAL0, REG_CAL1, REG_CAL2, REG_CAL3:
            cell_cal[cfg_index - REG_CAL0] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_reports.push_back(detect_tap(op_t'(in_tuser), in_tdata[CELL_W-1:0],
                                             in_tdata[CELL_W +: SB]));
      if (out_tvalid && out_tready) begin
        seen = out_tdata[5:0];
        if (awaited_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t: unexpected result transfer, data %h", $realtime, out_tdata);
        end else begin
          want = awaited_reports.pop_front();
          if (seen.trigger_active  !== want.trigger_active ||
              seen.trigger_event   !== want.trigger_event  ||
              seen.trigger_cell    !== want.trigger_cell   ||
              seen.sample_rejected !== want.sample_rejected) begin
            errors++;
            if (errors <= 10)
              $display({"%t: result mismatch: exp act %0d ev %0d cell %0d rej %0d,",
                        " got act %0d ev %0d cell %0d rej %0d"},
                       $realtime, want.trigger_active, want.trigger_event,
                       want.trigger_cell, want.sample_rejected, seen.trigger_active,
                       seen.trigger_event, seen.trigger_cell, seen.sample_rejected);
          end
        end
      end
    end
    outstanding <= awaited_reports.size();
    mismatches  <= errors;
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the load cell tap detector. A directed opening
// walks the calibration extremes, the 0.6 rejection edge, each trigger event,
// zero and short hold times and ticks; random phases with fresh register
// settings follow. Sender bursts and receiver stalls run throughout; the
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import ltd_pkg::*;

  localparam int SB   = SAMPLE_BITS_DEF;
  localparam int IN_W = ((CELL_W + SB + 7) / 8) * 8;

  // index with no register behind it; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // the odd single stall
    RX_CHOKE    // ready when the count mod 11 is below 3
  } rx_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;   // [1:0] cell, [25:2] raw sample
  logic                 in_tuser   = 1'b0; // [0] operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [0] active, [2:1] event, [4:3] cell, [5] rejected
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index  = '0;
  logic [2*SB-1:0]      cfg_data   = '0;

  int                   mismatch_count;
  int                   reports_due;

  // what the calibration registers were last given; used to aim samples
  logic [2*SB-1:0]      cal_shadow [CAL_REGS];
  int                   burst_left = 0;
  int unsigned          rx_count   = 0;
  rx_mode_t             rx_mode    = RX_OPEN;

  loadcell_tap_detector u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ltd_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches(mismatch_count),
    .outstanding(reports_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: a new pattern is drawn whenever the low six bits of rx_count
  // wrap, so stalls land on every phase of the traffic, with fully open stretches in between.
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count[5:0] == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) != 0);
      default:   out_tready <= ((rx_count % 11) < 3);
    endcase
  end

  // One sample or tick transfer. Bursts of random length; a burst may open
  // with a gap. tvalid stays high across back-to-back items.
  task automatic send_item(input op_t op, input logic [CELL_W-1:0] cell_id,
                           input logic [SB-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({raw, cell_id});
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every awaited result has been transferred, then
  // let the pipeline (two stages) run dry.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes every register; calibration comes from cal_shadow. Only called
  // once the block is idle.
  task automatic load_setting(input logic [TAP_W-1:0] tap,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [HOLD_W-1:0] hold, input bit poke_spare);
    logic [REG_IDX_W-1:0] idx;
    logic [2*SB-1:0]      value;
    for (int k = 0; k < (poke_spare ? 8 : 7); k++) begin
      case (k)
        0:       idx = REG_TAP;
        1:       idx = REG_WEIGHT;
        2:       idx = REG_HOLD;
        3:       idx = REG_CAL0;
        4:       idx = REG_CAL1;
        5:       idx = REG_CAL2;
        6:       idx = REG_CAL3;
        default: idx = REG_SPARE;
      endcase
      case (idx)
        REG_TAP:    value = (2*SB)'(tap);
        REG_WEIGHT: value = (2*SB)'(weight);
        REG_HOLD:   value = (2*SB)'(hold);
        REG_SPARE:  value = {16'($urandom), 32'($urandom)};
        default:    value = cal_shadow[idx - REG_CAL0];
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int zval, oval, span, step, pick;
    logic [CELL_W-1:0] cell_id;
    for (int k = 0; k < CAL_REGS; k++) cal_shadow[k] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: all zero values are 0, so only a reading of exactly
    // zero survives; full-scale samples of both signs are rejected.
    send_item(OP_SAMPLE, 2'd0, 24'd0);
    send_item(OP_SAMPLE, 2'd1, 24'h7FFFFF);
    send_item(OP_SAMPLE, 2'd2, 24'h800000);
    send_item(OP_SAMPLE, 2'd3, 24'd1);
    send_item(OP_TICK,   2'd3, 24'hFFFFFF);
    settle();

    // Calibration extremes; cell 3 puts the 0.6 edge at exactly 39322.
    cal_shadow[0] = {24'h7FFFFF, 24'h800000};
    cal_shadow[1] = {24'h800000, 24'h7FFFFF};
    cal_shadow[2] = {24'd100000, 24'd0};
    cal_shadow[3] = {24'd65536,  24'd0};
    load_setting(25'd1000, '1, 16'd2, 1'b0);
    send_item(OP_SAMPLE, 2'd0, 24'h7FFFFF);   // far beyond the zero value
    send_item(OP_SAMPLE, 2'd0, 24'h800000);   // lands on the offset
    send_item(OP_SAMPLE, 2'd2, 24'd50000);    // single-cell tap
    send_item(OP_SAMPLE, 2'd1, 24'h7FFFFF);   // updated while held
    send_item(OP_TICK,   2'd0, 24'd0);
    send_item(OP_TICK,   2'd0, 24'd0);        // hold runs out here
    send_item(OP_TICK,   2'd0, 24'd0);
    send_item(OP_SAMPLE, 2'd3, 24'd39322);    // on the edge: kept
    send_item(OP_SAMPLE, 2'd3, -24'sd39323);  // just over: rejected
    settle();

    // Taps out of reach, any weight trips, zero hold: events with no level.
    load_setting('1, '0, '0, 1'b1);
    send_item(OP_SAMPLE, 2'd2, 24'd1000);
    send_item(OP_SAMPLE, 2'd0, 24'd0);
    send_item(OP_TICK,   2'd1, 24'd0);
    settle();

    // Several cells moving together trip the summed change test.
    load_setting(25'd30000, '1, 16'd1, 1'b0);
    send_item(OP_SAMPLE, 2'd2, 24'd20000);
    send_item(OP_SAMPLE, 2'd1, 24'h7FFFFF - 24'd15000);
    send_item(OP_TICK,   2'd2, 24'd0);
    send_item(OP_SAMPLE, 2'd0, 24'h800000 + 24'd20000);
    send_item(OP_TICK,   2'd0, 24'd0);
    settle();

    // Random phases, each with fresh calibration and thresholds.
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < CAL_REGS; k++) begin
        zval = $urandom_range(2000, 3000000);
        if ($urandom_range(0, 1)) zval = -zval;
        oval = $urandom_range(0, 8000000) - 4000000;
        cal_shadow[k] = {24'(zval), 24'(oval)};
      end
      // last phase: one cell loses its zero value and rejects nearly all
      if (phase == 5) cal_shadow[$urandom_range(0, 3)][2*SB-1:SB] = '0;
      case (phase)
        0: load_setting(25'($urandom_range(500, 20000)), '1,
                        16'($urandom_range(1, 12)), 1'b0);
        1: load_setting('0, 26'($urandom_range(10000, 4000000)), 16'd1, 1'b0);
        2: load_setting('1, '0, '0, 1'b1);
        3: load_setting(25'($urandom_range(500, 40000)),
                        26'($urandom_range(10000, 4000000)),
                        16'($urandom_range(1, 20)), 1'b0);
        4: load_setting(25'($urandom_range(500, 20000)), '1, '1, 1'b0);
        default: load_setting(25'($urandom_range(0, 30000)),
                              26'($urandom_range(0, 8000000)),
                              16'($urandom_range(0, 6)), 1'b1);
      endcase
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          send_item(OP_TICK, 2'($urandom), 24'($urandom));
        end else if (pick < 30) begin
          send_item(OP_SAMPLE, 2'($urandom), 24'($urandom));
        end else begin
          // Realistic load: offset plus a swing inside (mostly) 0.6 of the
          // zero value; half the swings are small enough to sit under the
          // single-cell threshold and build up the summed change.
          cell_id = 2'($urandom_range(0, 3));
          zval = $signed(cal_shadow[cell_id][2*SB-1:SB]);
          oval = $signed(cal_shadow[cell_id][SB-1:0]);
          span = (zval < 0) ? -zval : zval;
          if ($urandom_range(0, 1)) span = span * 5 / 8;
          else span = (span / 2 < 4000) ? span / 2 : 4000;
          step = $urandom_range(0, span);
          if ($urandom_range(0, 1)) step = -step;
          send_item(OP_SAMPLE, cell_id, 24'(oval + step));
        end
      end
      settle();
    end

    if (mismatch_count == 0 && reports_due == 0) begin
      $display("loadcell_tap_detector verification clean");
    end else begin
      $display("loadcell_tap_detector verification failed");
    end
    $finish;
  end

  // Hang guard: ends the run as failed if the stimulus never finishes.
  initial begin
    #2_000_000;
    $display("loadcell_tap_detector verification failed");
    $finish;
  end

endmodule
